// File: rtl/core/lgc_pkg.sv
// ----------------------------------------------------------------------------
// lgc_pkg
// Shared constants, codes and types for the glyph cache slot row.
// ----------------------------------------------------------------------------
`default_nettype none

package lgc_pkg;

   // default sizes
   localparam int ENTRIES_DEF      = 16;
   localparam int GLYPH_BITS_DEF   = 32;
   localparam int FONT_ID_BITS_DEF = 8;

   // fixed field widths
   localparam int GLYPH_ID_BITS  = 32;
   localparam int FONT_SIZE_BITS = 16;
   localparam int CAP_BITS       = 5;
   localparam int EV_BITS        = 5;
   localparam int FUNC_BITS      = 3;

   localparam logic [CAP_BITS-1:0] CAP_RESET = 5'd16;
   localparam logic [EV_BITS-1:0]  EV_MAX    = 5'd31;

   // request operations
   localparam logic [FUNC_BITS-1:0] FUNC_INSERT = 3'd0;
   localparam logic [FUNC_BITS-1:0] FUNC_LOOKUP = 3'd1;
   localparam logic [FUNC_BITS-1:0] FUNC_PROBE  = 3'd2;
   localparam logic [FUNC_BITS-1:0] FUNC_REMOVE = 3'd3;
   localparam logic [FUNC_BITS-1:0] FUNC_CLEAR  = 3'd4;
   localparam logic [FUNC_BITS-1:0] FUNC_TRIM   = 3'd5;

   // slot row update modes
   localparam logic [2:0] MODE_HOLD  = 3'd0;
   localparam logic [2:0] MODE_FRONT = 3'd1;  // move hit entry to the head
   localparam logic [2:0] MODE_PUSH  = 3'd2;  // shift all toward tail, new at head
   localparam logic [2:0] MODE_PULL  = 3'd3;  // close the gap of a removed entry
   localparam logic [2:0] MODE_KILL  = 3'd4;  // drop slots at or past the limit

   // broadcast control to every slot
   typedef struct packed {
      logic [2:0] mode;
      logic       capture;
   } slot_ctl_type;

   // decisions of the control unit for one request
   typedef struct packed {
      logic [2:0]         mode;
      logic               status;
      logic               hit;
      logic               glyph_sel;
      logic [EV_BITS-1:0] evicted;
   } act_type;

endpackage

`default_nettype wire

// File: rtl/core/lgc_slot.sv
// ----------------------------------------------------------------------------
// lgc_slot
// One position of the recency row. Position equals recency rank: the head
// is the most recent entry. Each slot compares its key, and loads from its
// head-side or tail-side neighbor as the broadcast mode says.
// ----------------------------------------------------------------------------
`default_nettype none

module lgc_slot
   import lgc_pkg::*;
#(
   parameter int IDX        = 0,
   parameter int KEY_BITS   = 56,
   parameter int GLYPH_BITS = GLYPH_BITS_DEF,
   parameter int CNT_BITS   = 5
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire slot_ctl_type          ctl,
   input  wire logic [CNT_BITS-1:0]   limit,
   input  wire logic [KEY_BITS-1:0]   cmp_key,
   input  wire logic                  prev_valid,
   input  wire logic [KEY_BITS-1:0]   prev_key,
   input  wire logic [GLYPH_BITS-1:0] prev_glyph,
   input  wire logic                  next_valid,
   input  wire logic [KEY_BITS-1:0]   next_key,
   input  wire logic [GLYPH_BITS-1:0] next_glyph,
   input  wire logic                  seen_in,
   output logic                       seen_out,
   input  wire logic [GLYPH_BITS-1:0] hit_glyph_in,
   output logic [GLYPH_BITS-1:0]      hit_glyph_out,
   output logic                       fwd_valid,
   output logic                       slot_valid,
   output logic [KEY_BITS-1:0]        key,
   output logic [GLYPH_BITS-1:0]      glyph
);

   localparam logic [CNT_BITS-1:0] POS = CNT_BITS'(IDX);

   logic                  valid_ff, valid_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [GLYPH_BITS-1:0] glyph_ff, glyph_in;
   logic                  match_ff, match_in;
   logic                  keep;

   // slot survives the limit
   assign keep      = valid_ff && (POS < limit);
   assign fwd_valid = keep;

   // match chains toward tail (seen) and toward head (glyph)
   assign seen_out      = seen_in | match_ff;
   assign hit_glyph_out = match_ff ? glyph_ff : hit_glyph_in;

   // match captured when the request is taken
   assign match_in = ctl.capture ? (valid_ff && (key_ff == cmp_key)) : match_ff;

   // slot update
   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      glyph_in = glyph_ff;
      unique case (ctl.mode)
         MODE_FRONT: begin
            if (!seen_in) begin
               valid_in = prev_valid;
               key_in   = prev_key;
               glyph_in = prev_glyph;
            end
         end
         MODE_PUSH: begin
            valid_in = prev_valid;
            key_in   = prev_key;
            glyph_in = prev_glyph;
         end
         MODE_PULL: begin
            if (seen_in || match_ff) begin
               valid_in = next_valid;
               key_in   = next_key;
               glyph_in = next_glyph;
            end
         end
         MODE_KILL: begin
            valid_in = keep;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   // payload
   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      glyph_ff <= glyph_in;
   end

   assign slot_valid = valid_ff;
   assign key        = key_ff;
   assign glyph      = glyph_ff;

endmodule

`default_nettype wire

// File: rtl/core/lgc_ctrl.sv
// ----------------------------------------------------------------------------
// lgc_ctrl
// Decides the row update, new entry count and response fields of one
// request from its operation, the hit flag, the count and the capacity.
// ----------------------------------------------------------------------------
`default_nettype none

module lgc_ctrl
   import lgc_pkg::*;
#(
   parameter int ENTRIES  = ENTRIES_DEF,
   parameter int CNT_BITS = 5
) (
   input  wire logic [FUNC_BITS-1:0] func,
   input  wire logic                 hit,
   input  wire logic [CNT_BITS-1:0]  count,
   input  wire logic [CAP_BITS-1:0]  capacity,
   output act_type                   act,
   output logic [CNT_BITS-1:0]       limit,
   output logic [CNT_BITS-1:0]       count_next
);

   localparam int SW = (CNT_BITS > CAP_BITS) ? CNT_BITS : CAP_BITS;

   logic [SW-1:0]       cap_ext;
   logic [CNT_BITS-1:0] eff_cap;
   logic [CNT_BITS-1:0] tgt;
   logic [CNT_BITS-1:0] ev;
   logic [SW-1:0]       ev_ext;

   // capacity clipped to the slot count
   assign cap_ext = SW'(capacity);
   assign eff_cap = (cap_ext > SW'(ENTRIES)) ? CNT_BITS'(ENTRIES) : cap_ext[CNT_BITS-1:0];

   // count kept before an insert of a new key
   assign tgt = (count >= eff_cap) ? (eff_cap - 1'b1) : count;

   always_comb begin
      act.mode      = MODE_HOLD;
      act.status    = 1'b0;
      act.hit       = 1'b0;
      act.glyph_sel = 1'b0;
      limit         = count;
      count_next    = count;
      ev            = '0;
      unique case (func)
         FUNC_INSERT: begin
            act.hit = hit;
            if (eff_cap != '0) begin
               if (hit) begin
                  act.mode = MODE_FRONT;
               end else begin
                  act.mode   = MODE_PUSH;
                  limit      = tgt;
                  ev         = count - tgt;
                  count_next = tgt + 1'b1;
               end
            end
         end
         FUNC_LOOKUP: begin
            act.hit = hit;
            if (hit) begin
               act.mode      = MODE_FRONT;
               act.glyph_sel = 1'b1;
            end else begin
               act.status = 1'b1;
            end
         end
         FUNC_PROBE: begin
            act.hit = hit;
         end
         FUNC_REMOVE: begin
            act.hit = hit;
            if (hit) begin
               act.mode   = MODE_PULL;
               count_next = count - 1'b1;
            end
         end
         FUNC_CLEAR: begin
            act.mode   = MODE_KILL;
            limit      = '0;
            count_next = '0;
         end
         FUNC_TRIM: begin
            if (count > eff_cap) begin
               act.mode   = MODE_KILL;
               limit      = eff_cap;
               ev         = count - eff_cap;
               count_next = eff_cap;
            end
         end
         default: begin
         end
      endcase

      // eviction count saturates
      ev_ext      = SW'(ev);
      act.evicted = (ev_ext > SW'(EV_MAX)) ? EV_MAX : ev_ext[EV_BITS-1:0];
   end

endmodule

`default_nettype wire

// File: rtl/core/lru_glyph_cache.sv
// ----------------------------------------------------------------------------
// lru_glyph_cache
// Fully associative least-recently-used glyph handle store built as a row
// of slots ordered by recency.
// ----------------------------------------------------------------------------
// Usage:
//   req_* channel carries one operation with a (font, glyph, size) key and a
//   handle; rsp_* returns status, hit, handle and eviction count, one
//   response per request. csr_wr_en/csr_wr_data set the capacity; the user
//   writes it only while no request is in flight, the block does not enforce this.
//   When a request is taken every slot compares its key and registers the
//   match; in the later update cycle the slot row shifts, drops or moves
//   entries in one step and the response register loads. A new request is
//   taken only once the previous one has updated the slot row; trim and
//   eviction finish in the same update cycle since slot position is
//   recency rank.
//   The response appears the cycle after the update and a new request is
//   taken meanwhile. If rsp_stall holds the response, the next update waits
//   and req_stall stays high until the response register frees.
//   Reset empties the store, sets capacity to 16 and clears both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module lru_glyph_cache
   import lgc_pkg::*;
#(
   parameter int ENTRIES      = ENTRIES_DEF,
   parameter int GLYPH_BITS   = GLYPH_BITS_DEF,
   parameter int FONT_ID_BITS = FONT_ID_BITS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   // request channel
   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic [FUNC_BITS-1:0]     req_func,
   input  wire logic [FONT_ID_BITS-1:0]  req_font_id,
   input  wire logic [GLYPH_ID_BITS-1:0] req_glyph_id,
   input  wire logic [FONT_SIZE_BITS-1:0] req_font_size,
   input  wire logic [GLYPH_BITS-1:0]    req_glyph_in,
   // response channel
   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic                          rsp_status,
   output logic                          rsp_hit,
   output logic [GLYPH_BITS-1:0]         rsp_glyph_out,
   output logic [EV_BITS-1:0]            rsp_evicted_count,
   // capacity register
   input  wire logic                     csr_wr_en,
   input  wire logic [CAP_BITS-1:0]      csr_wr_data
);

   localparam int KEY_BITS = FONT_ID_BITS + GLYPH_ID_BITS + FONT_SIZE_BITS;
   localparam int CNT_BITS = $clog2(ENTRIES + 1);

   logic                  busy_ff, busy_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [CAP_BITS-1:0]   cap_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic [FUNC_BITS-1:0]  func_ff;
   logic [KEY_BITS-1:0]   key_ff;
   logic [GLYPH_BITS-1:0] glyph_ff;
   logic                  rsp_status_ff;
   logic                  rsp_hit_ff;
   logic [GLYPH_BITS-1:0] rsp_glyph_ff;
   logic [EV_BITS-1:0]    rsp_ev_ff;

   logic                  req_take;
   logic                  update_go;
   logic [KEY_BITS-1:0]   req_key;
   slot_ctl_type          slot_ctl;
   act_type               act;
   logic [CNT_BITS-1:0]   limit;
   logic [CNT_BITS-1:0]   count_next;
   logic                  hit;
   logic [GLYPH_BITS-1:0] hit_glyph;
   logic [GLYPH_BITS-1:0] head_glyph;

   logic                  fwd_valid [ENTRIES];
   logic [KEY_BITS-1:0]   slot_key  [ENTRIES];
   logic [GLYPH_BITS-1:0] slot_glyph[ENTRIES];
   logic [ENTRIES-1:0]    valid_vec;
   logic                  seen      [ENTRIES+1];
   logic [GLYPH_BITS-1:0] gchain    [ENTRIES+1];

   // handshake
   assign req_stall = busy_ff;
   assign req_take  = req_valid && !busy_ff;
   assign update_go = busy_ff && (!rsp_valid_ff || !rsp_stall);
   assign busy_in   = req_take || (busy_ff && !update_go);
   assign rsp_valid_in = update_go || (rsp_valid_ff && rsp_stall);

   assign req_key = {req_font_id, req_glyph_id, req_font_size};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
      end else begin
         busy_ff      <= busy_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            cap_ff <= csr_wr_data;
         end
         if (update_go) begin
            count_ff <= count_next;
         end
      end
   end

   // request hold
   always_ff @(posedge clock) begin
      if (req_take) begin
         func_ff  <= req_func;
         key_ff   <= req_key;
         glyph_ff <= req_glyph_in;
      end
   end

   // operation decode
   lgc_ctrl #(
      .ENTRIES  (ENTRIES),
      .CNT_BITS (CNT_BITS)
   ) u_ctrl (
      .func       (func_ff),
      .hit        (hit),
      .count      (count_ff),
      .capacity   (cap_ff),
      .act        (act),
      .limit      (limit),
      .count_next (count_next)
   );

   // broadcast to the slot row
   assign slot_ctl.capture = req_take;
   assign slot_ctl.mode    = update_go ? act.mode : MODE_HOLD;
   assign head_glyph       = (act.mode == MODE_FRONT) ? hit_glyph : glyph_ff;

   assign seen[0]          = 1'b0;
   assign gchain[ENTRIES]  = '0;
   assign hit              = seen[ENTRIES];
   assign hit_glyph        = gchain[0];

   // slot row, head is most recent
   for (genvar i = 0; i < ENTRIES; i++) begin : g_slot
      logic                  p_valid;
      logic [KEY_BITS-1:0]   p_key;
      logic [GLYPH_BITS-1:0] p_glyph;
      logic                  n_valid;
      logic [KEY_BITS-1:0]   n_key;
      logic [GLYPH_BITS-1:0] n_glyph;

      if (i == 0) begin : g_head
         assign p_valid = 1'b1;
         assign p_key   = key_ff;
         assign p_glyph = head_glyph;
      end else begin : g_mid
         assign p_valid = fwd_valid[i-1];
         assign p_key   = slot_key[i-1];
         assign p_glyph = slot_glyph[i-1];
      end

      if (i == ENTRIES - 1) begin : g_tail
         assign n_valid = 1'b0;
         assign n_key   = '0;
         assign n_glyph = '0;
      end else begin : g_body
         assign n_valid = fwd_valid[i+1];
         assign n_key   = slot_key[i+1];
         assign n_glyph = slot_glyph[i+1];
      end

      lgc_slot #(
         .IDX        (i),
         .KEY_BITS   (KEY_BITS),
         .GLYPH_BITS (GLYPH_BITS),
         .CNT_BITS   (CNT_BITS)
      ) u_slot (
         .clock         (clock),
         .reset         (reset),
         .ctl           (slot_ctl),
         .limit         (limit),
         .cmp_key       (req_key),
         .prev_valid    (p_valid),
         .prev_key      (p_key),
         .prev_glyph    (p_glyph),
         .next_valid    (n_valid),
         .next_key      (n_key),
         .next_glyph    (n_glyph),
         .seen_in       (seen[i]),
         .seen_out      (seen[i+1]),
         .hit_glyph_in  (gchain[i+1]),
         .hit_glyph_out (gchain[i]),
         .fwd_valid     (fwd_valid[i]),
         .slot_valid    (valid_vec[i]),
         .key           (slot_key[i]),
         .glyph         (slot_glyph[i])
      );
   end

   // response register
   always_ff @(posedge clock) begin
      if (update_go) begin
         rsp_status_ff <= act.status;
         rsp_hit_ff    <= act.hit;
         rsp_glyph_ff  <= act.glyph_sel ? hit_glyph : '0;
         rsp_ev_ff     <= act.evicted;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_hit           = rsp_hit_ff;
   assign rsp_glyph_out     = rsp_glyph_ff;
   assign rsp_evicted_count = rsp_ev_ff;

`ifndef SYNTHESIS
   // valid slots stay packed at the head and match the count
   a_packed: assert property (@(posedge clock) disable iff (reset)
      ((valid_vec & (valid_vec + 1'b1)) == '0) &&
      ($countones(valid_vec) == int'(count_ff)))
      else $error("slot row not packed or count mismatch");

   // a response only follows an update of a request in flight
   a_rsp_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(busy_ff))
      else $error("response without request");

   // a miss status never comes with a hit
   a_status: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff |-> !rsp_hit_ff && (rsp_glyph_ff == '0))
      else $error("miss status with hit data");

   // count never exceeds the slot count
   a_count: assert property (@(posedge clock) disable iff (reset)
      update_go |=> (count_ff <= CNT_BITS'(ENTRIES)))
      else $error("entry count out of range");
`endif

endmodule

`default_nettype wire

// File: sim/tb_lru_glyph_cache.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lru_glyph_cache
// Self-checking bench for the LRU glyph cache. A queue of requests feeds a
// clocked driver with random gaps. A clocked monitor stalls responses at
// random and checks each one against a behavioral LRU predictor that runs
// when the request is taken. The capacity register is rewritten between
// phases while the cache is idle, including zero, oversize and lowered
// values.
// ----------------------------------------------------------------------------

module tb_lru_glyph_cache;
   import lgc_pkg::*;

   localparam int ENTRIES      = ENTRIES_DEF;
   localparam int GLYPH_BITS   = GLYPH_BITS_DEF;
   localparam int FONT_ID_BITS = FONT_ID_BITS_DEF;
   localparam int KEY_BITS     = FONT_ID_BITS + GLYPH_ID_BITS + FONT_SIZE_BITS;
   localparam int KEY_POOL     = 20;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int PRINT_LIMIT  = 200;

   // codes with no operation behind them
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_6 = 3'd6;
   localparam logic [FUNC_BITS-1:0] FUNC_SPARE_7 = 3'd7;

   typedef struct packed {
      logic [FUNC_BITS-1:0]      func;
      logic [FONT_ID_BITS-1:0]   font_id;
      logic [GLYPH_ID_BITS-1:0]  glyph_id;
      logic [FONT_SIZE_BITS-1:0] font_size;
      logic [GLYPH_BITS-1:0]     glyph_in;
   } glyph_req_type;

   typedef struct packed {
      logic                  status;
      logic                  hit;
      logic [GLYPH_BITS-1:0] glyph_out;
      logic [EV_BITS-1:0]    evicted;
   } glyph_rsp_type;

   // dut signals
   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_stall;
   logic [FUNC_BITS-1:0]      req_func = '0;
   logic [FONT_ID_BITS-1:0]   req_font_id = '0;
   logic [GLYPH_ID_BITS-1:0]  req_glyph_id = '0;
   logic [FONT_SIZE_BITS-1:0] req_font_size = '0;
   logic [GLYPH_BITS-1:0]     req_glyph_in = '0;
   logic                      rsp_valid;
   logic                      rsp_stall = 1'b0;
   logic                      rsp_status;
   logic                      rsp_hit;
   logic [GLYPH_BITS-1:0]     rsp_glyph_out;
   logic [EV_BITS-1:0]        rsp_evicted_count;
   logic                      csr_wr_en = 1'b0;
   logic [CAP_BITS-1:0]       csr_wr_data = '0;

   // request and response bookkeeping
   glyph_req_type queued_ops[$];
   glyph_rsp_type awaited_answers[$];
   glyph_req_type shown_op;
   int         mismatch_count = 0;
   int         cycle_count = 0;

   // predicted cache contents, slot age 0 is most recent
   logic                  slot_used [ENTRIES] = '{default: 1'b0};
   logic [KEY_BITS-1:0]   slot_key [ENTRIES];
   logic [GLYPH_BITS-1:0] slot_handle [ENTRIES];
   int                    slot_age [ENTRIES];
   int                    used_count = 0;
   logic [CAP_BITS-1:0]   cap_reg = CAP_RESET;

   // keys reused often so that hits, refreshes and evictions happen
   logic [FONT_ID_BITS-1:0]   pool_font [KEY_POOL];
   logic [GLYPH_ID_BITS-1:0]  pool_glyph [KEY_POOL];
   logic [FONT_SIZE_BITS-1:0] pool_size [KEY_POOL];

   lru_glyph_cache i_dut (
      .clock             (clock),
      .reset             (reset),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_func          (req_func),
      .req_font_id       (req_font_id),
      .req_glyph_id      (req_glyph_id),
      .req_font_size     (req_font_size),
      .req_glyph_in      (req_glyph_in),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_status        (rsp_status),
      .rsp_hit           (rsp_hit),
      .rsp_glyph_out     (rsp_glyph_out),
      .rsp_evicted_count (rsp_evicted_count),
      .csr_wr_en         (csr_wr_en),
      .csr_wr_data       (csr_wr_data)
   );

   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT) begin
         $display("mismatch at cycle %0d: %s got %0h want %0h", cycle_count, what, got,
                  want);
      end
   endtask

   // move a slot to the front, younger entries age by one
   function automatic void promote_slot(input int s);
      int r;
      r = slot_age[s];
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_used[i] && slot_age[i] < r) slot_age[i]++;
      end
      slot_age[s] = 0;
   endfunction

   function automatic void evict_oldest();
      int pick;
      pick = -1;
      for (int i = 0; i < ENTRIES; i++) begin
         if (slot_used[i] && (pick < 0 || slot_age[i] > slot_age[pick])) pick = i;
      end
      if (pick >= 0) begin
         slot_used[pick] = 1'b0;
         if (used_count > 0) used_count--;
      end
   endfunction

   function automatic glyph_rsp_type predict_cache_op(input glyph_req_type op);
      glyph_rsp_type       ans;
      logic [KEY_BITS-1:0] k;
      int                  at;
      int                  free_at;
      int                  lim;
      int                  ev;
      ans = '0;
      k = {op.font_id, op.glyph_id, op.font_size};
      at = -1;
      free_at = -1;
      ev = 0;
      lim = (cap_reg > ENTRIES) ? ENTRIES : int'(cap_reg);
      if (op.func <= FUNC_REMOVE) begin
         for (int i = 0; i < ENTRIES; i++) begin
            if (slot_used[i] && slot_key[i] == k) at = i;
         end
         ans.hit = (at >= 0);
      end
      case (op.func)
         FUNC_INSERT: begin
            if (lim != 0) begin
               if (at >= 0) begin
                  promote_slot(at);
               end else begin
                  // make room, also when a lowered capacity left too many
                  while (used_count > 0 && used_count >= lim) begin
                     evict_oldest();
                     ev++;
                  end
                  for (int i = ENTRIES - 1; i >= 0; i--) begin
                     if (!slot_used[i]) free_at = i;
                  end
                  if (free_at >= 0) begin
                     for (int i = 0; i < ENTRIES; i++) begin
                        if (slot_used[i]) slot_age[i]++;
                     end
                     slot_used[free_at] = 1'b1;
                     slot_key[free_at] = k;
                     slot_handle[free_at] = op.glyph_in;
                     slot_age[free_at] = 0;
                     used_count++;
                  end
               end
            end
         end
         FUNC_LOOKUP: begin
            if (at >= 0) begin
               ans.glyph_out = slot_handle[at];
               promote_slot(at);
            end else begin
               ans.status = 1'b1;
            end
         end
         FUNC_REMOVE: begin
            if (at >= 0) begin
               for (int i = 0; i < ENTRIES; i++) begin
                  if (slot_used[i] && slot_age[i] > slot_age[at]) slot_age[i]--;
               end
               slot_used[at] = 1'b0;
               if (used_count > 0) used_count--;
            end
         end
         FUNC_CLEAR: begin
            for (int i = 0; i < ENTRIES; i++) slot_used[i] = 1'b0;
            used_count = 0;
         end
         FUNC_TRIM: begin
            while (used_count > lim) begin
               evict_oldest();
               ev++;
            end
         end
         default: begin
         end
      endcase
      ans.evicted = (ev > int'(EV_MAX)) ? EV_MAX : EV_BITS'(ev);
      return ans;
   endfunction

   function automatic void push_op(input logic [FUNC_BITS-1:0] func,
                                   input logic [FONT_ID_BITS-1:0] font,
                                   input logic [GLYPH_ID_BITS-1:0] gid,
                                   input logic [FONT_SIZE_BITS-1:0] fsize,
                                   input logic [GLYPH_BITS-1:0] handle);
      glyph_req_type op;
      op.func = func;
      op.font_id = font;
      op.glyph_id = gid;
      op.font_size = fsize;
      op.glyph_in = handle;
      queued_ops.push_back(op);
   endfunction

   // request driver with random gaps between requests
   int gap_left = 0;
   int send_burst = 0;
   bit send_idles = 1'b0;

   always @(posedge clock) begin : drive_requests
      logic sending;
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         sending = req_valid;
         if (req_valid && !req_stall) begin
            awaited_answers.push_back(predict_cache_op(shown_op));
            sending = 1'b0;
         end
         if (!sending) begin
            if (gap_left > 0) begin
               gap_left--;
            end else if (queued_ops.size() > 0) begin
               shown_op = queued_ops.pop_front();
               req_func <= shown_op.func;
               req_font_id <= shown_op.font_id;
               req_glyph_id <= shown_op.glyph_id;
               req_font_size <= shown_op.font_size;
               req_glyph_in <= shown_op.glyph_in;
               sending = 1'b1;
               if (send_burst == 0) begin
                  send_burst = $urandom_range(8, 40);
                  send_idles = ($urandom_range(0, 2) != 0);
               end
               send_burst--;
               gap_left = send_idles ? $urandom_range(0, 19) : 0;
            end
         end
         req_valid <= sending;
      end
   end

   // response monitor with random stalls
   int stall_left = 0;
   int take_burst = 0;
   bit take_stalls = 1'b0;

   always @(posedge clock) begin : check_responses
      glyph_rsp_type want;
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_answers.size() == 0) begin
               report_mismatch("response with none pending", 32'd1, 32'd0);
            end else begin
               want = awaited_answers.pop_front();
               if (rsp_status !== want.status)
                  report_mismatch("status", 32'(rsp_status), 32'(want.status));
               if (rsp_hit !== want.hit)
                  report_mismatch("hit", 32'(rsp_hit), 32'(want.hit));
               if (rsp_glyph_out !== want.glyph_out)
                  report_mismatch("glyph_out", 32'(rsp_glyph_out), 32'(want.glyph_out));
               if (rsp_evicted_count !== want.evicted)
                  report_mismatch("evicted_count", 32'(rsp_evicted_count),
                                  32'(want.evicted));
            end
            if (take_burst == 0) begin
               take_burst = $urandom_range(8, 40);
               take_stalls = ($urandom_range(0, 2) != 0);
            end
            take_burst--;
            stall_left = take_stalls ? $urandom_range(0, 19) : 0;
         end
         if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // run limit
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   task automatic wait_idle();
      while (queued_ops.size() != 0 || awaited_answers.size() != 0 || req_valid)
         @(posedge clock);
      // let the response register drain
      repeat (4) @(posedge clock);
   endtask

   task automatic write_capacity(input logic [CAP_BITS-1:0] cap);
      wait_idle();
      csr_wr_en <= 1'b1;
      csr_wr_data <= cap;
      @(posedge clock);
      cap_reg = cap;
      csr_wr_en <= 1'b0;
   endtask

   // one capacity setting followed by random requests over the key pool
   task automatic run_phase(input logic [CAP_BITS-1:0] cap, input int n);
      int            r;
      int            p;
      glyph_req_type op;
      write_capacity(cap);
      for (int i = 0; i < 6; i++) begin
         p = $urandom_range(0, KEY_POOL - 1);
         pool_font[p] = FONT_ID_BITS'($urandom);
         pool_glyph[p] = $urandom;
         pool_size[p] = FONT_SIZE_BITS'($urandom);
      end
      // first a new key so a lowered capacity evicts down at once
      push_op(FUNC_INSERT, FONT_ID_BITS'($urandom), $urandom, FONT_SIZE_BITS'($urandom),
              $urandom);
      for (int i = 1; i < n; i++) begin
         r = $urandom_range(0, 99);
         if (r < 36) op.func = FUNC_INSERT;
         else if (r < 60) op.func = FUNC_LOOKUP;
         else if (r < 70) op.func = FUNC_PROBE;
         else if (r < 82) op.func = FUNC_REMOVE;
         else if (r < 84) op.func = FUNC_CLEAR;
         else if (r < 97) op.func = FUNC_TRIM;
         else op.func = ($urandom_range(0, 1) != 0) ? FUNC_SPARE_7 : FUNC_SPARE_6;
         if ($urandom_range(0, 99) < 85) begin
            p = $urandom_range(0, KEY_POOL - 1);
            op.font_id = pool_font[p];
            op.glyph_id = pool_glyph[p];
            op.font_size = pool_size[p];
         end else begin
            op.font_id = FONT_ID_BITS'($urandom);
            op.glyph_id = $urandom;
            op.font_size = FONT_SIZE_BITS'($urandom);
         end
         op.glyph_in = GLYPH_BITS'($urandom);
         queued_ops.push_back(op);
      end
   endtask

   initial begin
      for (int i = 0; i < KEY_POOL; i++) begin
         pool_font[i] = FONT_ID_BITS'($urandom);
         pool_glyph[i] = $urandom;
         pool_size[i] = FONT_SIZE_BITS'($urandom);
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // directed: extremes, every operation, refresh of a present key
      push_op(FUNC_LOOKUP, '0, '0, '0, '1);
      push_op(FUNC_INSERT, '0, '0, '0, '0);
      push_op(FUNC_INSERT, '1, '1, '1, '1);
      push_op(FUNC_LOOKUP, '1, '1, '1, '0);
      push_op(FUNC_LOOKUP, '0, '0, '0, '1);
      push_op(FUNC_INSERT, '0, '0, '0, 32'h1234_5678);
      push_op(FUNC_LOOKUP, '0, '0, '0, '0);
      push_op(FUNC_PROBE, '1, '1, '1, '0);
      push_op(FUNC_PROBE, 8'h80, 32'h8000_0000, 16'h8000, '1);
      push_op(FUNC_REMOVE, '0, '0, '0, '0);
      push_op(FUNC_REMOVE, '0, '0, '0, '0);
      push_op(FUNC_LOOKUP, '0, '0, '0, '0);
      push_op(FUNC_SPARE_6, '1, '1, '1, '1);
      push_op(FUNC_SPARE_7, '1, '1, '1, '1);
      push_op(FUNC_INSERT, 8'hA5, 32'h5A5A_5A5A, 16'hA5A5, 32'h5A5A_5A5A);
      push_op(FUNC_TRIM, '1, '1, '1, '1);
      push_op(FUNC_CLEAR, '1, '1, '1, '1);
      push_op(FUNC_LOOKUP, '1, '1, '1, '0);
      push_op(FUNC_PROBE, 8'hA5, 32'h5A5A_5A5A, 16'hA5A5, '0);

      // zero capacity on an empty store
      write_capacity(5'd0);
      push_op(FUNC_INSERT, 8'h3C, 32'hC3C3_C3C3, 16'h3C3C, 32'hFFFF_0000);
      push_op(FUNC_LOOKUP, 8'h3C, 32'hC3C3_C3C3, 16'h3C3C, '0);
      push_op(FUNC_TRIM, '0, '0, '0, '0);

      run_phase(5'd16, 90);
      run_phase(5'd0, 50);
      run_phase(5'd16, 100);
      run_phase(5'd3, 80);
      run_phase(5'd31, 90);
      run_phase(5'd1, 70);
      run_phase(5'd8, 100);
      run_phase(5'd17, 60);
      run_phase(5'd5, 90);
      run_phase(5'd12, 70);
      run_phase(5'd16, 50);

      wait_idle();
      repeat (10) @(posedge clock);
      if (mismatch_count == 0 && awaited_answers.size() == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
